// ----- rtl/accel_feedforward_byte_encoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the feed-forward byte encoder
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_FEEDFORWARD_BYTE_ENCODER_CORE_ASSERT_SVH
`define ACCEL_FEEDFORWARD_BYTE_ENCODER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define FFBE_ASSERT_SAME(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FFBE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/ffbe_pkg.sv -----
// ----------------------------------------------------------------------------
// ffbe_pkg
// Shared types and constants of the feed-forward byte encoder.
// ----------------------------------------------------------------------------
package ffbe_pkg;

	// field widths fixed by the register map and result format
	localparam int RANGE_W   = 15;
	localparam int GAIN_W    = 9;
	localparam int LEN_W     = 20;
	localparam int FRAC_W    = 8;
	localparam int R_W       = RANGE_W + FRAC_W;   // range in Q15.8
	localparam int FILT_W    = 24;                 // filter state, Q16.8
	localparam int OUT_W     = 16;
	localparam int CODE_W    = 8;
	localparam int QUO_W     = 7;
	localparam int NUM_W     = 31;                 // dividend of the code divider
	localparam int CNT_W     = 3;
	localparam int DIV_STEPS = 7;
	localparam int ROUND_HALF = 128;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [RANGE_W-1:0] RANGE_ONE = 15'd1;
	localparam logic [GAIN_W-1:0]  GAIN_FULL = 9'd256;
	localparam logic [QUO_W-1:0]   CODE_ZERO = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_LENGTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_LENGTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_NEGATE     = 3'd6;

	typedef struct packed {
		logic [RANGE_W-1:0] accel_range;
		logic [GAIN_W-1:0]  filter_gain;
		logic [GAIN_W-1:0]  bias_gain;
		logic [LEN_W-1:0]   straight_length;
		logic [LEN_W-1:0]   curve_length;
		logic [LEN_W-1:0]   guard_length;
		logic               axis_negate;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		accel_range:     15'd1024,
		filter_gain:     9'd90,
		bias_gain:       9'd5,
		straight_length: 20'd2400,
		curve_length:    20'd2513,
		guard_length:    20'd80,
		axis_negate:     1'b1
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_BIAS_MUL,
		ST_BIAS_ACC,
		ST_CLIP,
		ST_FILT_MUL,
		ST_FILT_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic load_sample;
		logic filt_clear;
		logic bias_seed;
		logic mul_en;
		logic mul_filt;
		logic bias_acc;
		logic clip_en;
		logic filt_acc;
		logic div_init;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fresh;
		logic present;
		logic active;
		logic known;
		logic div_last;
	} dp_status_t;

endpackage

// ----- rtl/ffbe_if.sv -----
// ----------------------------------------------------------------------------
// ffbe_if
// Valid/ready channels of the encoder: sample words, result words, register
// writes.
// ----------------------------------------------------------------------------
interface ffbe_in_if #(
	parameter int ACCEL_WIDTH = 16,
	parameter int DIST_WIDTH  = 20
);
	logic                          valid;
	logic                          ready;
	logic                          frame_fresh;
	logic                          accel_present;
	logic signed [ACCEL_WIDTH-1:0] accel_raw;
	logic                          route_active;
	logic                          lap_mode;
	logic [DIST_WIDTH-1:0]         distance_travelled;

	modport source (
		output valid, frame_fresh, accel_present, accel_raw, route_active, lap_mode,
		output distance_travelled,
		input  ready
	);
	modport sink (
		input  valid, frame_fresh, accel_present, accel_raw, route_active, lap_mode,
		input  distance_travelled,
		output ready
	);
endinterface

interface ffbe_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [ffbe_pkg::CODE_W-1:0]          code_byte;
	logic                                 on_straight;
	logic signed [ffbe_pkg::OUT_W-1:0]    filtered_accel;

	modport source (output valid, code_byte, on_straight, filtered_accel, input ready);
	modport sink   (input valid, code_byte, on_straight, filtered_accel, output ready);
endinterface

interface ffbe_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ffbe_pkg::CFG_IDX_W-1:0]    index;
	logic [ffbe_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ffbe_cfg.sv -----
// ----------------------------------------------------------------------------
// ffbe_cfg
// Configuration register bank; writes are always taken.
// ----------------------------------------------------------------------------
module ffbe_cfg (
	input  logic            clk,
	input  logic            arst_n,
	ffbe_cfg_if.sink        cfg,
	output ffbe_pkg::cfg_t  regs
);

	ffbe_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= ffbe_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				ffbe_pkg::REG_ACCEL_RANGE:
					regs_q.accel_range <= cfg.data[ffbe_pkg::RANGE_W-1:0];
				ffbe_pkg::REG_FILTER_GAIN:
					regs_q.filter_gain <= cfg.data[ffbe_pkg::GAIN_W-1:0];
				ffbe_pkg::REG_BIAS_GAIN:
					regs_q.bias_gain <= cfg.data[ffbe_pkg::GAIN_W-1:0];
				ffbe_pkg::REG_STRAIGHT_LENGTH:
					regs_q.straight_length <= cfg.data[ffbe_pkg::LEN_W-1:0];
				ffbe_pkg::REG_CURVE_LENGTH:
					regs_q.curve_length <= cfg.data[ffbe_pkg::LEN_W-1:0];
				ffbe_pkg::REG_GUARD_LENGTH:
					regs_q.guard_length <= cfg.data[ffbe_pkg::LEN_W-1:0];
				ffbe_pkg::REG_AXIS_NEGATE:
					regs_q.axis_negate <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ffbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffbe_ctrl
// Sequencer of the encoder: walks one sample word through bias tracking,
// filtering and the code divider, and owns the result handshake.
// ----------------------------------------------------------------------------
`include "accel_feedforward_byte_encoder_core_assert.svh"

module ffbe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ffbe_pkg::dp_status_t  status,
	output ffbe_pkg::dp_cmd_t     cmd
);

	ffbe_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ffbe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ffbe_pkg::ST_SAMPLE;
				end
			end
			ffbe_pkg::ST_SAMPLE: begin
				cmd.load_sample = 1'b1;
				priority if (!status.fresh) begin
					cmd.filt_clear = 1'b1;
					state_d        = ffbe_pkg::ST_DIV_INIT;
				end else if (!status.present) begin
					state_d = ffbe_pkg::ST_DIV_INIT;
				end else if (status.active) begin
					state_d = ffbe_pkg::ST_CLIP;
				end else if (!status.known) begin
					cmd.bias_seed = 1'b1;
					state_d       = ffbe_pkg::ST_CLIP;
				end else begin
					state_d = ffbe_pkg::ST_BIAS_MUL;
				end
			end
			ffbe_pkg::ST_BIAS_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ffbe_pkg::ST_BIAS_ACC;
			end
			ffbe_pkg::ST_BIAS_ACC: begin
				cmd.bias_acc = 1'b1;
				state_d      = ffbe_pkg::ST_CLIP;
			end
			ffbe_pkg::ST_CLIP: begin
				cmd.clip_en = 1'b1;
				state_d     = ffbe_pkg::ST_FILT_MUL;
			end
			ffbe_pkg::ST_FILT_MUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_filt = 1'b1;
				state_d      = ffbe_pkg::ST_FILT_ACC;
			end
			ffbe_pkg::ST_FILT_ACC: begin
				cmd.filt_acc = 1'b1;
				state_d      = ffbe_pkg::ST_DIV_INIT;
			end
			ffbe_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ffbe_pkg::ST_DIV;
			end
			ffbe_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ffbe_pkg::ST_FIN;
				end
			end
			ffbe_pkg::ST_FIN: begin
				// load the result register once it is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ffbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffbe_pkg::ST_IDLE;
			end
		endcase
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`FFBE_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ffbe_pkg::ST_SAMPLE, "accepted word did not start processing")
	`FFBE_ASSERT_NEXT(a_fin_waits, clk, arst_n, state_q == ffbe_pkg::ST_FIN && out_valid_q && !out_ready, state_q == ffbe_pkg::ST_FIN, "pending result overwritten")
	`FFBE_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == ffbe_pkg::ST_DIV && status.div_last, state_q == ffbe_pkg::ST_FIN, "divider did not hand over")

endmodule

// ----- rtl/ffbe_dp.sv -----
// ----------------------------------------------------------------------------
// ffbe_dp
// Datapath of the encoder: sample conditioning, bias and filter state, one
// shared gain multiplier, a restoring code divider and the result register.
// ----------------------------------------------------------------------------
`include "accel_feedforward_byte_encoder_core_assert.svh"

module ffbe_dp #(
	parameter int ACCEL_WIDTH = 16,
	parameter int DIST_WIDTH  = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffbe_pkg::cfg_t                    cfg_regs,
	input  logic                              frame_fresh,
	input  logic                              accel_present,
	input  logic signed [ACCEL_WIDTH-1:0]     accel_raw,
	input  logic                              route_active,
	input  logic                              lap_mode,
	input  logic [DIST_WIDTH-1:0]             distance_travelled,
	input  ffbe_pkg::dp_cmd_t                 cmd,
	output ffbe_pkg::dp_status_t              status,
	output logic [ffbe_pkg::CODE_W-1:0]       code_byte,
	output logic                              on_straight,
	output logic signed [ffbe_pkg::OUT_W-1:0] filtered_accel
);

	localparam int SW = ACCEL_WIDTH + ffbe_pkg::FRAC_W;            // sample, Q.8
	localparam int AW = ffbe_pkg::FILT_W + 1;
	localparam int MW = (ACCEL_WIDTH + 9 > AW) ? ACCEL_WIDTH + 9 : AW;
	localparam int PW = MW + ffbe_pkg::GAIN_W + 1;
	localparam int CW = ((DIST_WIDTH > ffbe_pkg::LEN_W + 2) ? DIST_WIDTH
		: ffbe_pkg::LEN_W + 2) + 2;
	localparam logic signed [ACCEL_WIDTH-1:0] RAW_MIN = {1'b1, {(ACCEL_WIDTH-1){1'b0}}};
	localparam logic signed [ACCEL_WIDTH-1:0] RAW_MAX = {1'b0, {(ACCEL_WIDTH-1){1'b1}}};

	// captured input word
	logic                          fresh_q, present_q, active_q, lap_q;
	logic signed [ACCEL_WIDTH-1:0] raw_q;
	logic [DIST_WIDTH-1:0]         dist_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			fresh_q   <= frame_fresh;
			present_q <= accel_present;
			raw_q     <= accel_raw;
			active_q  <= route_active;
			lap_q     <= lap_mode;
			dist_q    <= distance_travelled;
		end
	end

	// range in Q15.8, zero range taken as one LSB
	logic [ffbe_pkg::R_W-1:0] r_w;
	assign r_w = {(cfg_regs.accel_range == '0) ? ffbe_pkg::RANGE_ONE : cfg_regs.accel_range,
		{ffbe_pkg::FRAC_W{1'b0}}};

	// sample: optional negation with saturation, widened to Q.8
	logic signed [ACCEL_WIDTH-1:0] neg_w, axis_w;
	logic signed [SW-1:0]          samp_w;
	logic signed [SW-1:0]          samp_q;

	assign neg_w  = (raw_q == RAW_MIN) ? RAW_MAX : -raw_q;
	assign axis_w = cfg_regs.axis_negate ? neg_w : raw_q;
	assign samp_w = {axis_w, {ffbe_pkg::FRAC_W{1'b0}}};

	// lap window bounds, signed so a negative bound never matches
	logic signed [CW-1:0] len_s_w, len_c_w, len_g_w;
	logic signed [CW-1:0] b_lo_q, b_mid_q, b_hi_q;

	assign len_s_w = signed'(CW'(cfg_regs.straight_length));
	assign len_c_w = signed'(CW'(cfg_regs.curve_length));
	assign len_g_w = signed'(CW'(cfg_regs.guard_length));

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			samp_q  <= samp_w;
			b_lo_q  <= len_s_w - len_g_w;
			b_mid_q <= len_s_w + len_c_w + len_g_w;
			b_hi_q  <= len_s_w + len_s_w + len_c_w - len_g_w;
		end
	end

	// state registers
	logic signed [SW-1:0]               bias_q;
	logic                               known_q;
	logic signed [ffbe_pkg::FILT_W-1:0] filt_q;
	logic signed [ffbe_pkg::FILT_W-1:0] clip_q;

	// shared gain multiplier
	logic [ffbe_pkg::GAIN_W-1:0] gf_w, gb_w;
	logic signed [ffbe_pkg::GAIN_W:0] gain_w;
	logic signed [MW-1:0] bdiff_w, fdiff_w, op_w;
	logic signed [PW-1:0] prod_w, prod_q, psum_w, rnd_w;

	assign gf_w    = cfg_regs.filter_gain[ffbe_pkg::GAIN_W-1] ? ffbe_pkg::GAIN_FULL
		: cfg_regs.filter_gain;
	assign gb_w    = cfg_regs.bias_gain[ffbe_pkg::GAIN_W-1] ? ffbe_pkg::GAIN_FULL
		: cfg_regs.bias_gain;
	assign bdiff_w = MW'(samp_q) - MW'(bias_q);
	assign fdiff_w = MW'(clip_q) - MW'(filt_q);
	assign op_w    = cmd.mul_filt ? fdiff_w : bdiff_w;
	assign gain_w  = {1'b0, cmd.mul_filt ? gf_w : gb_w};
	assign prod_w  = op_w * gain_w;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_w;
		end
	end

	// round half up, then drop eight fraction bits
	assign psum_w = prod_q + PW'(ffbe_pkg::ROUND_HALF);
	assign rnd_w  = psum_w >>> ffbe_pkg::FRAC_W;

	// bias correction and clamp to +/- range
	logic signed [MW-1:0] corr_w, rpos_w;
	logic signed [MW-1:0] clip_w;

	assign corr_w = known_q ? bdiff_w : MW'(samp_q);
	assign rpos_w = signed'(MW'(r_w));

	always_comb begin
		if (corr_w > rpos_w) begin
			clip_w = rpos_w;
		end else if (corr_w < -rpos_w) begin
			clip_w = -rpos_w;
		end else begin
			clip_w = corr_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clip_en) begin
			clip_q <= clip_w[ffbe_pkg::FILT_W-1:0];
		end
	end

	// bias tracker and low-pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			known_q <= 1'b0;
			filt_q  <= '0;
		end else begin
			if (cmd.bias_seed) begin
				bias_q  <= samp_w;
				known_q <= 1'b1;
			end else if (cmd.bias_acc) begin
				bias_q <= bias_q + signed'(rnd_w[SW-1:0]);
			end
			if (cmd.filt_clear) begin
				filt_q <= '0;
			end else if (cmd.filt_acc) begin
				filt_q <= filt_q + signed'(rnd_w[ffbe_pkg::FILT_W-1:0]);
			end
		end
	end

	// code divider setup: clamp the filter value, build dividend and divisor
	logic signed [AW-1:0] fe_w, ra_pos_w, a_w;
	logic [AW-1:0]        ra_sum_w;
	logic                 aneg_w;
	logic [ffbe_pkg::R_W-1:0] a_mag_w;
	logic [ffbe_pkg::NUM_W-1:0] num_w;

	assign fe_w     = AW'(filt_q);
	assign ra_pos_w = signed'(AW'(r_w));

	always_comb begin
		if (fe_w > ra_pos_w) begin
			a_w = ra_pos_w;
		end else if (fe_w < -ra_pos_w) begin
			a_w = -ra_pos_w;
		end else begin
			a_w = fe_w;
		end
	end

	assign aneg_w   = a_w[AW-1] || (a_w == '0);
	assign ra_sum_w = AW'(r_w) + a_w;
	assign a_mag_w  = a_w[ffbe_pkg::R_W-1:0];

	// at or below zero: 129r + 128a = 128(r + a) + r; above: 126a + r
	always_comb begin
		if (aneg_w) begin
			num_w = ffbe_pkg::NUM_W'({ra_sum_w[ffbe_pkg::R_W-1:0], 7'b0})
				+ ffbe_pkg::NUM_W'(r_w);
		end else begin
			num_w = ffbe_pkg::NUM_W'({a_mag_w, 7'b0}) - ffbe_pkg::NUM_W'({a_mag_w, 1'b0})
				+ ffbe_pkg::NUM_W'(r_w);
		end
	end

	// restoring divider by 2r, one quotient bit a cycle
	logic [ffbe_pkg::NUM_W-1:0] rem_q, dsh_q;
	logic [ffbe_pkg::QUO_W-1:0] quo_q;
	logic [ffbe_pkg::CNT_W-1:0] cnt_q;
	logic                       aneg_q;
	logic                       fit_w;

	assign fit_w = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= num_w;
			dsh_q  <= ffbe_pkg::NUM_W'({r_w, 7'b0});
			quo_q  <= '0;
			cnt_q  <= ffbe_pkg::CNT_W'(ffbe_pkg::DIV_STEPS - 1);
			aneg_q <= aneg_w;
		end else if (cmd.div_step) begin
			if (fit_w) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[ffbe_pkg::QUO_W-2:0], fit_w};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// straight segment flag
	logic signed [CW-1:0] dist_w;
	logic                 straight_w;

	assign dist_w     = signed'(CW'(dist_q));
	assign straight_w = !(lap_q && active_q) || (dist_w < b_lo_q)
		|| ((dist_w >= b_mid_q) && (dist_w < b_hi_q));

	// result register
	logic [ffbe_pkg::QUO_W-1:0]        code7_w;
	logic signed [AW-1:0]              fsum_w, fshift_w;
	logic [ffbe_pkg::CODE_W-1:0]       code_q;
	logic                              straight_q;
	logic signed [ffbe_pkg::OUT_W-1:0] fout_q;

	assign code7_w  = aneg_q ? quo_q : ffbe_pkg::CODE_ZERO + quo_q;
	assign fsum_w   = AW'(filt_q) + AW'(ffbe_pkg::ROUND_HALF);
	assign fshift_w = fsum_w >>> ffbe_pkg::FRAC_W;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			code_q     <= {straight_w, code7_w};
			straight_q <= straight_w;
			fout_q     <= fshift_w[ffbe_pkg::OUT_W-1:0];
		end
	end

	assign code_byte      = code_q;
	assign on_straight    = straight_q;
	assign filtered_accel = fout_q;

	assign status.fresh    = fresh_q;
	assign status.present  = present_q;
	assign status.active   = active_q;
	assign status.known    = known_q;
	assign status.div_last = (cnt_q == '0);

	`FFBE_ASSERT_SAME(a_quot_range, clk, arst_n, cmd.out_load, quo_q <= ffbe_pkg::CODE_ZERO, "code quotient out of range")
	`FFBE_ASSERT_NEXT(a_seed_known, clk, arst_n, cmd.bias_seed, known_q, "bias seed did not mark bias known")
	`FFBE_ASSERT_NEXT(a_filt_cleared, clk, arst_n, cmd.filt_clear, filt_q == '0, "stale word did not clear the filter")

endmodule

// ----- rtl/accel_feedforward_byte_encoder_core.sv -----
// ----------------------------------------------------------------------------
// accel_feedforward_byte_encoder_core
// Bias-tracked, clamped and low-pass filtered forward acceleration, encoded
// into one byte with a straight-segment flag.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | word
//  samples   | in  | valid / ready  | fresh, present, raw sample, route flags, distance
//  results   | out | valid / ready  | code byte, straight flag, filtered value
//  cfg       | in  | valid / ready  | register index, write data (always ready)
//
//  An accepted sample word is carried to the result register, and the next word
//  is taken in the cycle after that; no new word is accepted while one is in
//  work: the shared gain multiplier serves bias and filter in turn, and the code
//  divider produces one quotient bit a cycle.
//  Reset loads the register defaults and clears bias and filter state.
//  A finished result sits in the output register while the next word is
//  accepted; the sequencer only holds before writing a new result over it.
// ----------------------------------------------------------------------------
module accel_feedforward_byte_encoder_core #(
	parameter int ACCEL_WIDTH = 16,
	parameter int DIST_WIDTH  = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	ffbe_in_if.sink     samples,
	ffbe_out_if.source  results,
	ffbe_cfg_if.sink    cfg
);

	ffbe_pkg::cfg_t       cfg_regs;
	ffbe_pkg::dp_cmd_t    cmd;
	ffbe_pkg::dp_status_t status;

	// register bank
	ffbe_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// sequencer
	ffbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic
	ffbe_dp #(
		.ACCEL_WIDTH (ACCEL_WIDTH),
		.DIST_WIDTH  (DIST_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_regs           (cfg_regs),
		.frame_fresh        (samples.frame_fresh),
		.accel_present      (samples.accel_present),
		.accel_raw          (samples.accel_raw),
		.route_active       (samples.route_active),
		.lap_mode           (samples.lap_mode),
		.distance_travelled (samples.distance_travelled),
		.cmd                (cmd),
		.status             (status),
		.code_byte          (results.code_byte),
		.on_straight        (results.on_straight),
		.filtered_accel     (results.filtered_accel)
	);

endmodule

// ----- tb/tb_accel_feedforward_byte_encoder_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_feedforward_byte_encoder_core
// Self-checking bench for the feed-forward byte encoder. Sample words are
// driven on the input channel with random gaps, result words are taken with
// random stalls, and each result is compared field by field with a bit-exact
// prediction of bias tracking, clamping, low-pass filtering, code
// quantisation and the straight-segment windows. Register settings are
// changed between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_accel_feedforward_byte_encoder_core;

	localparam int AW             = 16;
	localparam int DW             = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 24;

	typedef struct packed {
		logic          fresh;
		logic          present;
		logic [AW-1:0] raw;
		logic          active;
		logic          lap;
		logic [DW-1:0] travel;
	} sample_t;

	typedef struct packed {
		logic [ffbe_pkg::CODE_W-1:0] code;
		logic                        straight;
		logic [ffbe_pkg::OUT_W-1:0]  filt;
	} code_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ffbe_in_if #(.ACCEL_WIDTH(AW), .DIST_WIDTH(DW)) smp_if ();
	ffbe_out_if res_if ();
	ffbe_cfg_if cfg_if ();

	accel_feedforward_byte_encoder_core #(
		.ACCEL_WIDTH(AW),
		.DIST_WIDTH (DW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp_if),
		.results(res_if),
		.cfg    (cfg_if)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted encoder state and register copy
	ffbe_pkg::cfg_t model_cfg;
	longint     est_bias;
	bit         bias_valid;
	longint     est_filt;

	code_word_t expected_q [$];
	code_word_t exp_word;
	int unsigned words_sent;
	int unsigned mismatches;
	int unsigned idle_cycles;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	bit          sink_hold_req = 1'b0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// floor((x + 128) / 256): round half up when dropping 8 fraction bits
	function automatic longint round_q8(input longint x);
		return (x + ffbe_pkg::ROUND_HALF) >>> ffbe_pkg::FRAC_W;
	endfunction

	function automatic longint gain_val(input logic [ffbe_pkg::GAIN_W-1:0] g);
		return (g > ffbe_pkg::GAIN_FULL) ? longint'(ffbe_pkg::GAIN_FULL) : longint'(g);
	endfunction

	task automatic predict_word(input sample_t s, output code_word_t w);
		longint rng, smp, a, q, d, sl, cl, gl, f, smax;
		bit     straight;
		rng = (model_cfg.accel_range == '0)
			? longint'(ffbe_pkg::RANGE_ONE) << ffbe_pkg::FRAC_W
			: longint'(model_cfg.accel_range) << ffbe_pkg::FRAC_W;
		smax = (longint'(1) <<< (AW-1)) - 1;
		if (!s.fresh) begin
			est_filt = 0;
		end else if (s.present) begin
			smp = longint'($signed(s.raw));
			if (model_cfg.axis_negate)
				smp = -smp;
			// negating the most negative sample saturates
			smp = clip(smp, -smax - 1, smax) <<< ffbe_pkg::FRAC_W;
			if (!s.active) begin
				if (!bias_valid) begin
					est_bias   = smp;
					bias_valid = 1'b1;
				end else begin
					est_bias += round_q8(gain_val(model_cfg.bias_gain) * (smp - est_bias));
				end
			end
			if (bias_valid)
				smp -= est_bias;
			smp = clip(smp, -rng, rng);
			est_filt += round_q8(gain_val(model_cfg.filter_gain) * (smp - est_filt));
		end

		// lap windows, bounds taken as signed
		d  = longint'(s.travel);
		sl = longint'(model_cfg.straight_length);
		cl = longint'(model_cfg.curve_length);
		gl = longint'(model_cfg.guard_length);
		straight = !(s.lap && s.active) || (d < sl - gl)
			|| (d >= sl + cl + gl && d < 2 * sl + cl - gl);

		// 64 levels below zero, 63 above
		a = clip(est_filt, -rng, rng);
		if (a <= 0)
			q = (129 * rng + 128 * a) / (2 * rng);
		else
			q = longint'(ffbe_pkg::CODE_ZERO) + (126 * a + rng) / (2 * rng);
		q = clip(q, 0, 127);
		f = round_q8(est_filt);
		w.code     = {straight, q[ffbe_pkg::QUO_W-1:0]};
		w.straight = straight;
		w.filt     = f[ffbe_pkg::OUT_W-1:0];
	endtask

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------
	function automatic sample_t sample_of(input bit fresh, input bit present,
		input logic [AW-1:0] raw, input bit active, input bit lap, input logic [DW-1:0] travel);
		sample_t s;
		s.fresh   = fresh;
		s.present = present;
		s.raw     = raw;
		s.active  = active;
		s.lap     = lap;
		s.travel  = travel;
		return s;
	endfunction

	function automatic sample_t noise_sample();
		return sample_of(1'($urandom), 1'($urandom), AW'($urandom), 1'($urandom),
			1'($urandom), DW'($urandom));
	endfunction

	// offer one sample word; valid stays high afterwards for back-to-back words
	task automatic send_word(input sample_t s);
		int unsigned gap;
		code_word_t  w;
		gap = src_idle ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid              <= 1'b1;
		smp_if.frame_fresh        <= s.fresh;
		smp_if.accel_present      <= s.present;
		smp_if.accel_raw          <= s.raw;
		smp_if.route_active       <= s.active;
		smp_if.lap_mode           <= s.lap;
		smp_if.distance_travelled <= s.travel;
		do @(posedge clk); while (!smp_if.ready);
		predict_word(s, w);
		expected_q.push_back(w);
		words_sent++;
	endtask

	// sender pause until every outstanding result word has come back
	task automatic drain_results();
		smp_if.valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	task automatic put_reg(input logic [ffbe_pkg::CFG_IDX_W-1:0] idx,
		input logic [ffbe_pkg::CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			ffbe_pkg::REG_ACCEL_RANGE:
				model_cfg.accel_range = data[ffbe_pkg::RANGE_W-1:0];
			ffbe_pkg::REG_FILTER_GAIN:
				model_cfg.filter_gain = data[ffbe_pkg::GAIN_W-1:0];
			ffbe_pkg::REG_BIAS_GAIN:
				model_cfg.bias_gain = data[ffbe_pkg::GAIN_W-1:0];
			ffbe_pkg::REG_STRAIGHT_LENGTH:
				model_cfg.straight_length = data[ffbe_pkg::LEN_W-1:0];
			ffbe_pkg::REG_CURVE_LENGTH:
				model_cfg.curve_length = data[ffbe_pkg::LEN_W-1:0];
			ffbe_pkg::REG_GUARD_LENGTH:
				model_cfg.guard_length = data[ffbe_pkg::LEN_W-1:0];
			ffbe_pkg::REG_AXIS_NEGATE:
				model_cfg.axis_negate = data[0];
			default: ;
		endcase
	endtask

	// full register set, only called with the block quiet
	task automatic write_regs(input ffbe_pkg::cfg_t c);
		put_reg(ffbe_pkg::REG_ACCEL_RANGE,     ffbe_pkg::CFG_DATA_W'(c.accel_range));
		put_reg(ffbe_pkg::REG_FILTER_GAIN,     ffbe_pkg::CFG_DATA_W'(c.filter_gain));
		put_reg(ffbe_pkg::REG_BIAS_GAIN,       ffbe_pkg::CFG_DATA_W'(c.bias_gain));
		put_reg(ffbe_pkg::REG_STRAIGHT_LENGTH, ffbe_pkg::CFG_DATA_W'(c.straight_length));
		put_reg(ffbe_pkg::REG_CURVE_LENGTH,    ffbe_pkg::CFG_DATA_W'(c.curve_length));
		put_reg(ffbe_pkg::REG_GUARD_LENGTH,    ffbe_pkg::CFG_DATA_W'(c.guard_length));
		put_reg(ffbe_pkg::REG_AXIS_NEGATE,     ffbe_pkg::CFG_DATA_W'(c.axis_negate));
		cfg_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stall per word, long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		res_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				n = HOLD_CYCLES;
			end else begin
				n = sink_idle ? $urandom_range(0, 12) : 0;
			end
			if (n != 0) begin
				res_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready));
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: code %02h straight %0b filt %0d",
						res_if.code_byte, res_if.on_straight, $signed(res_if.filtered_accel));
			end else begin
				exp_word = expected_q.pop_front();
				if (res_if.code_byte !== exp_word.code || res_if.on_straight !== exp_word.straight
					|| res_if.filtered_accel !== exp_word.filt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: code exp %02h got %02h, %s%0b got %0b, %s%0d got %0d",
							exp_word.code, res_if.code_byte,
							"straight exp ", exp_word.straight, res_if.on_straight,
							"filt exp ", $signed(exp_word.filt), $signed(res_if.filtered_accel));
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset settings: bias seeding, saturation, clamping, every lap window edge
	task automatic test_directed();
		int unsigned marks [8];
		int unsigned k;
		int unsigned sl, cl, gl;
		sl = ffbe_pkg::CFG_RESET.straight_length;
		cl = ffbe_pkg::CFG_RESET.curve_length;
		gl = ffbe_pkg::CFG_RESET.guard_length;
		marks = '{0, sl - gl - 1, sl - gl, sl + cl + gl - 1, sl + cl + gl,
			2 * sl + cl - gl - 1, 2 * sl + cl - gl, (1 << DW) - 1};
		send_word(sample_of(1'b0, 1'b1, 16'sd300, 1'b0, 1'b0, '0));
		send_word(sample_of(1'b1, 1'b0, 16'sd300, 1'b0, 1'b0, '0));
		// first taken sample seeds the bias, the next one tracks it
		send_word(sample_of(1'b1, 1'b1, 16'sd256, 1'b0, 1'b0, '0));
		send_word(sample_of(1'b1, 1'b1, 16'sd512, 1'b0, 1'b0, '0));
		send_word(sample_of(1'b1, 1'b1, 16'sh8000, 1'b1, 1'b0, '0));
		send_word(sample_of(1'b1, 1'b1, 16'sh7FFF, 1'b1, 1'b0, '0));
		send_word(sample_of(1'b1, 1'b1, 16'sd0, 1'b1, 1'b0, '0));
		// drive the filter to both rails
		for (k = 0; k < 3; k++)
			send_word(sample_of(1'b1, 1'b1, 16'sh8000, 1'b1, 1'b0, '0));
		for (k = 0; k < 3; k++)
			send_word(sample_of(1'b1, 1'b1, 16'sh7FFF, 1'b1, 1'b0, '0));
		for (k = 0; k < 8; k++)
			send_word(sample_of(1'b1, 1'b1, AW'($urandom), 1'b1, 1'b1, DW'(marks[k])));
		// route idle or other route mode counts as straight
		send_word(sample_of(1'b1, 1'b1, 16'sd100, 1'b0, 1'b1, DW'(3000)));
		send_word(sample_of(1'b1, 1'b1, 16'sd100, 1'b1, 1'b0, DW'(3000)));
		send_word(sample_of(1'b0, 1'b0, 16'sd0, 1'b1, 1'b1, DW'(3000)));
	endtask

	// a handful of words on one extreme register setting
	task automatic probe_cfg(input ffbe_pkg::cfg_t c);
		int unsigned k;
		drain_results();
		write_regs(c);
		send_word(sample_of(1'b1, 1'b1, 16'sh8000, 1'b0, 1'b1, '0));
		send_word(sample_of(1'b1, 1'b1, 16'sh7FFF, 1'b1, 1'b1, '1));
		send_word(sample_of(1'b1, 1'b1, 16'sh8000, 1'b1, 1'b1, DW'(c.straight_length)));
		send_word(sample_of(1'b1, 1'b1, 16'sd0, 1'b1, 1'b1, DW'($urandom)));
		for (k = 0; k < 6; k++)
			send_word(noise_sample());
	endtask

	task automatic test_config_extremes();
		ffbe_pkg::cfg_t c;
		// zero range, full gains
		c = ffbe_pkg::CFG_RESET;
		c.accel_range = '0;
		c.filter_gain = ffbe_pkg::GAIN_FULL;
		c.bias_gain   = ffbe_pkg::GAIN_FULL;
		probe_cfg(c);
		// widest range, gains above full scale, axis not negated
		c = ffbe_pkg::CFG_RESET;
		c.accel_range = '1;
		c.filter_gain = '1;
		c.bias_gain   = ffbe_pkg::GAIN_W'(257);
		c.axis_negate = 1'b0;
		probe_cfg(c);
		// frozen filter and bias, all lengths zero
		c = ffbe_pkg::CFG_RESET;
		c.accel_range     = ffbe_pkg::RANGE_ONE;
		c.filter_gain     = '0;
		c.bias_gain       = '0;
		c.straight_length = '0;
		c.curve_length    = '0;
		c.guard_length    = '0;
		probe_cfg(c);
		// all lengths at their maximum
		c = ffbe_pkg::CFG_RESET;
		c.straight_length = '1;
		c.curve_length    = '1;
		c.guard_length    = '1;
		probe_cfg(c);
		// guard wider than the straight: negative lower bound
		c = ffbe_pkg::CFG_RESET;
		c.straight_length = ffbe_pkg::LEN_W'(100);
		c.curve_length    = ffbe_pkg::LEN_W'(50);
		c.guard_length    = ffbe_pkg::LEN_W'(500);
		probe_cfg(c);
	endtask

	// result side held off while the sender keeps offering back to back
	task automatic test_stall_fill();
		int unsigned k;
		drain_results();
		write_regs(ffbe_pkg::CFG_RESET);
		src_idle      = 1'b0;
		sink_hold_req = 1'b1;
		for (k = 0; k < 30; k++)
			send_word(sample_of(1'b1, 1'b1, AW'($urandom), 1'b1, 1'b1,
				DW'($urandom_range(0, 8000))));
		src_idle = 1'b1;
	endtask

	function automatic logic [ffbe_pkg::GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ffbe_pkg::GAIN_FULL;
			2: return ffbe_pkg::GAIN_W'($urandom_range(257, 511));
			default: return ffbe_pkg::GAIN_W'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic ffbe_pkg::cfg_t random_cfg();
		ffbe_pkg::cfg_t c;
		case ($urandom_range(0, 5))
			0: c.accel_range = '0;
			1: c.accel_range = ffbe_pkg::RANGE_ONE;
			2: c.accel_range = '1;
			default: c.accel_range = ffbe_pkg::RANGE_W'($urandom_range(64, 4096));
		endcase
		c.filter_gain     = random_gain();
		c.bias_gain       = random_gain();
		c.straight_length = ffbe_pkg::LEN_W'($urandom_range(0, 3000));
		c.curve_length    = ffbe_pkg::LEN_W'($urandom_range(0, 3000));
		c.guard_length    = ($urandom_range(0, 4) == 0)
			? ffbe_pkg::LEN_W'($urandom_range(0, 4000))
			: ffbe_pkg::LEN_W'($urandom_range(0, 150));
		if ($urandom_range(0, 7) == 0)
			c.straight_length = '1;
		c.axis_negate = 1'($urandom);
		return c;
	endfunction

	// sensor value drifting around the last one, with the odd jump
	function automatic logic [AW-1:0] drift(input logic [AW-1:0] acc);
		if ($urandom_range(0, 15) == 0)
			return AW'($urandom);
		return acc + AW'($urandom_range(0, 1023)) - AW'(512);
	endfunction

	// standstill stretches for bias tracking, then a route run over the windows
	task automatic run_routes(input int unsigned n);
		int unsigned   stop, seg, k, span, step_max;
		logic [AW-1:0] acc;
		logic [DW-1:0] odo;
		bit            lap;
		sample_t       s;
		stop = words_sent + n;
		acc  = AW'($urandom);
		while (words_sent < stop) begin
			seg = $urandom_range(3, 20);
			for (k = 0; k < seg; k++) begin
				acc = drift(acc);
				s = sample_of(1'b1, 1'b1, acc, 1'b0, 1'($urandom), DW'($urandom));
				if ($urandom_range(0, 9) == 0)
					s = noise_sample();
				send_word(s);
			end
			lap  = ($urandom_range(0, 3) != 0);
			odo  = '0;
			seg  = $urandom_range(20, 100);
			span = 2 * model_cfg.straight_length + model_cfg.curve_length
				+ 2 * model_cfg.guard_length + 1;
			step_max = span / seg * 2 + 1;
			if (step_max > 65535)
				step_max = 65535;
			for (k = 0; k < seg; k++) begin
				acc = drift(acc);
				odo = odo + DW'($urandom_range(0, step_max));
				s = sample_of(1'b1, 1'b1, acc, 1'b1, lap, odo);
				if ($urandom_range(0, 9) == 0)
					s = noise_sample();
				send_word(s);
			end
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end
	endtask

	task automatic test_random_routes();
		int unsigned ph;
		for (ph = 0; ph < 6; ph++) begin
			drain_results();
			write_regs(random_cfg());
			// one phase runs without gaps on either side
			src_idle  = (ph != 2);
			sink_idle = (ph != 2);
			run_routes(310);
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		smp_if.valid              <= 1'b0;
		smp_if.frame_fresh        <= 1'b0;
		smp_if.accel_present      <= 1'b0;
		smp_if.accel_raw          <= '0;
		smp_if.route_active       <= 1'b0;
		smp_if.lap_mode           <= 1'b0;
		smp_if.distance_travelled <= '0;
		cfg_if.valid              <= 1'b0;
		cfg_if.index              <= ffbe_pkg::REG_ACCEL_RANGE;
		cfg_if.data               <= '0;
		model_cfg   = ffbe_pkg::CFG_RESET;
		est_bias    = 0;
		bias_valid  = 1'b0;
		est_filt    = 0;
		words_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_config_extremes();
		test_stall_fill();
		test_random_routes();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
